FILE: rtl/tsob_pkg.sv
// tsob_pkg: shared types, codes and constants of the two-stack buffer
// used by tsob_ctrl, tsob_dp and two_stacks_one_buffer; depends on nothing
`default_nettype none

package tsob_pkg;

	// defaults of the top-level parameters
	localparam int DEPTH_DEF     = 256;
	localparam int WORD_BITS_DEF = 32;

	// fixed field widths
	localparam int CFG_BITS   = 9;   // active_size, also the width of both counts
	localparam int MODE_BITS  = 2;
	localparam int VAL_BITS   = 32;
	localparam int STAT_BITS  = 2;
	localparam int OUT_FIELDS = STAT_BITS + 2 * VAL_BITS + 2;
	localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;

	// operation codes carried in mode
	localparam logic [MODE_BITS-1:0] MODE_PUSH_LO = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_PUSH_HI = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_POP_LO  = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_POP_HI  = 2'd3;

	// result status codes
	localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_OVER  = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_UNDER = 2'd2;

	// reported top of an empty stack: -1000000000
	localparam logic [VAL_BITS-1:0] EMPTY_MARK = 32'hC465_3600;

	// controller to datapath commands
	typedef struct packed {
		logic cfg_wr;   // load active_size, clear both counts
		logic capture;  // take the input beat into the operand registers
		logic exec;     // check limits, write the store, update the counts
		logic rd;       // read both top entries
		logic load;     // fill the output register
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tsob_ctrl.sv
// tsob_ctrl: sequencer of the two-stack buffer, owns both stream handshakes
// and issues tsob_pkg::cmd_t commands to tsob_dp; depends on tsob_pkg
`default_nettype none

module tsob_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	output tsob_pkg::cmd_t     cmd
);
	import tsob_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;
	logic       in_acc;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign in_acc    = s_tvalid && s_tready;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_n = S_EXEC;
			S_EXEC: state_n = S_READ;
			S_READ: state_n = S_LOAD;
			S_LOAD: if (out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.cfg_wr  = cfg_valid && cfg_ready;
		cmd.capture = in_acc;
		cmd.exec    = (state_q == S_EXEC);
		cmd.rd      = (state_q == S_READ);
		cmd.load    = (state_q == S_LOAD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	a_acc_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_EXEC && !s_tready))
		else $error("accepted beat did not start execution");
	a_exec_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.rd)
		else $error("execute not followed by read");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> m_tvalid)
		else $error("loaded result not offered");

endmodule

`default_nettype wire

FILE: rtl/tsob_dp.sv
// tsob_dp: datapath of the two-stack buffer: counts, shared store, output register
// driven by tsob_pkg::cmd_t from tsob_ctrl; depends on tsob_pkg
`default_nettype none

module tsob_dp #(
	parameter int DEPTH     = tsob_pkg::DEPTH_DEF,
	parameter int WORD_BITS = tsob_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tsob_pkg::cmd_t                       cmd,
	input  wire logic [tsob_pkg::CFG_BITS-1:0]        cfg_data,
	input  wire logic [tsob_pkg::MODE_BITS-1:0]       mode,
	input  wire logic signed [tsob_pkg::VAL_BITS-1:0] push_value,
	output logic [tsob_pkg::OUT_BITS-1:0]             result
);
	import tsob_pkg::*;

	localparam int AW = $clog2(DEPTH);
	// effective size after reset: 256 saturated at DEPTH
	localparam logic [CFG_BITS-1:0] CAP_RST =
		(DEPTH < 256) ? CFG_BITS'(DEPTH) : CFG_BITS'(256);

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [CFG_BITS-1:0]        cap_q;
	logic [CFG_BITS-1:0]        low_q;
	logic [CFG_BITS-1:0]        high_q;
	logic [MODE_BITS-1:0]       mode_q;
	logic signed [VAL_BITS-1:0] value_q;
	logic [STAT_BITS-1:0]       status_q;
	logic [WORD_BITS-1:0]       lo_rd_q;
	logic [WORD_BITS-1:0]       hi_rd_q;
	logic [OUT_BITS-1:0]        result_q;

	logic [CFG_BITS:0]          used;
	logic                       full;
	logic [CFG_BITS-1:0]        low_n;
	logic [CFG_BITS-1:0]        high_n;
	logic [STAT_BITS-1:0]       status_n;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [WORD_BITS-1:0]       wr_word;
	logic [AW-1:0]              lo_addr;
	logic [AW-1:0]              hi_addr;
	logic [CFG_BITS-1:0]        cap_n;
	logic signed [VAL_BITS-1:0] lo_word;
	logic signed [VAL_BITS-1:0] hi_word;
	logic [VAL_BITS-1:0]        lo_top;
	logic [VAL_BITS-1:0]        hi_top;
	logic                       lo_empty;
	logic                       hi_empty;

	// size above DEPTH saturates
	assign cap_n = (32'(cfg_data) > 32'(DEPTH)) ? CFG_BITS'(DEPTH) : cfg_data;

	assign used    = {1'b0, low_q} + {1'b0, high_q};
	assign full    = (used >= {1'b0, cap_q});
	assign wr_word = WORD_BITS'(value_q);

	always_comb begin
		low_n    = low_q;
		high_n   = high_q;
		status_n = ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = AW'(low_q);
		unique case (mode_q)
			MODE_PUSH_LO: begin
				if (full) begin
					status_n = ST_OVER;
				end else begin
					wr_en = 1'b1;
					low_n = low_q + 1'b1;
				end
			end
			MODE_PUSH_HI: begin
				wr_addr = AW'(cap_q - high_q - 1'b1);
				if (full) begin
					status_n = ST_OVER;
				end else begin
					wr_en  = 1'b1;
					high_n = high_q + 1'b1;
				end
			end
			MODE_POP_LO: begin
				if (low_q == '0) status_n = ST_UNDER;
				else             low_n = low_q - 1'b1;
			end
			MODE_POP_HI: begin
				if (high_q == '0) status_n = ST_UNDER;
				else              high_n = high_q - 1'b1;
			end
			default: status_n = ST_DONE;
		endcase
	end

	// tops of both stacks after the step, only used when not empty
	assign lo_addr = AW'(low_q - 1'b1);
	assign hi_addr = AW'(cap_q - high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RST;
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q  <= cap_n;
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.exec) begin
			low_q  <= low_n;
			high_q <= high_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			value_q <= push_value;
		end
		if (cmd.exec)
			status_q <= status_n;
		if (cmd.exec && wr_en)
			mem[wr_addr] <= wr_word;
		if (cmd.rd) begin
			lo_rd_q <= mem[lo_addr];
			hi_rd_q <= mem[hi_addr];
		end
		if (cmd.load)
			result_q <= {(OUT_BITS - OUT_FIELDS)'(0), hi_empty, lo_empty,
				hi_top, lo_top, status_q};
	end

	assign lo_word  = VAL_BITS'(signed'(lo_rd_q));
	assign hi_word  = VAL_BITS'(signed'(hi_rd_q));
	assign lo_empty = (low_q == '0);
	assign hi_empty = (high_q == '0);
	assign lo_top   = lo_empty ? EMPTY_MARK : lo_word;
	assign hi_top   = hi_empty ? EMPTY_MARK : hi_word;
	assign result   = result_q;

	a_no_meet: assert property (@(posedge clk) disable iff (!arst_n)
		used <= {1'b0, cap_q})
		else $error("stacks overlap");
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !cmd.cfg_wr && status_n != ST_DONE) |=>
		($stable(low_q) && $stable(high_q)))
		else $error("refused operation changed a count");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cfg_wr |=> (low_q == '0 && high_q == '0))
		else $error("size write did not empty the stacks");

endmodule

`default_nettype wire

FILE: rtl/two_stacks_one_buffer.sv
// two_stacks_one_buffer: two stacks sharing one buffer, top level
// instantiates tsob_ctrl and tsob_dp; depends on tsob_pkg
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser: mode, tdata: push_value
// m_axis    out  m_axis_tvalid/tready       tdata: status, tops, empty flags
// cfg       in   cfg_valid/cfg_ready        cfg_data: active_size
//
// each beat goes through accept, store write and count update, registered read of
// both top entries and output register load, in that order; the next beat is taken
// the cycle after the load, so a new beat is not taken before the last one is loaded
// the shared store has one write and two read ports with registered read data
// reset clears both counts and sets active_size to 256 (saturated at DEPTH);
// the store itself is not cleared
// a stalled result stays in the output register while the next beat is taken;
// the load of that next result waits until the output is drained
`default_nettype none

module two_stacks_one_buffer #(
	parameter int DEPTH     = tsob_pkg::DEPTH_DEF,
	parameter int WORD_BITS = tsob_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// push_value [31:0]
	input  wire logic signed [tsob_pkg::VAL_BITS-1:0] s_axis_tdata,
	// mode [1:0]
	input  wire logic [tsob_pkg::MODE_BITS-1:0]       s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// status [1:0], low_top [33:2], high_top [65:34], low_empty [66],
	// high_empty [67], zero fill [71:68]
	output logic [tsob_pkg::OUT_BITS-1:0]             m_axis_tdata,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	// active_size [8:0]
	input  wire logic [tsob_pkg::CFG_BITS-1:0]        cfg_data
);
	import tsob_pkg::*;

	cmd_t cmd;

	// sequencer: handshakes and command timing
	tsob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// counts, shared store and output register
	tsob_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_data   (cfg_data),
		.mode       (s_axis_tuser),
		.push_value (s_axis_tdata),
		.result     (m_axis_tdata)
	);

endmodule

`default_nettype wire
